### rtl/tti_pkg.sv
// Shared types, widths and codes of the triangle-triangle intersection block.
`default_nettype none

package tti_pkg;

  // Coordinate and derived arithmetic widths.
  localparam int COORD_W = 16;
  localparam int TRI_W   = 9 * COORD_W;
  localparam int IN_TD_W = ((TRI_W + 7) / 8) * 8;
  localparam int OUT_TD_W = 8;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int NPRD_W  = 2 * EDGE_W;
  localparam int NRM_W   = 2 * EDGE_W + 1;
  localparam int DPRD_W  = NRM_W + EDGE_W;
  localparam int DST_W   = NRM_W + EDGE_W + 2;
  localparam int NUM_W   = COORD_W + DST_W + 1;
  localparam int DEN_W   = DST_W + 1;

  // Pipelined wide multiplier: operands split into MUL_NC chunks of MUL_CH bits.
  localparam int MUL_W   = NUM_W;
  localparam int PRD_W   = 2 * MUL_W;
  localparam int MUL_NC  = 3;
  localparam int MUL_CH  = (MUL_W + MUL_NC - 1) / MUL_NC;
  localparam int MUL_XW  = MUL_CH * MUL_NC;
  localparam int MUL_RW  = 2 * MUL_CH + MUL_CH * (MUL_NC - 1) + 2;
  localparam int MUL_TW  = 2 * MUL_XW;
  localparam int MUL_LAT = 5;

  // Stage indexes of the main pipeline.
  localparam int S_DST = 6;
  localparam int S_AX  = 4 + MUL_LAT;
  localparam int S_NUM = S_AX + MUL_LAT + 1;
  localparam int S_CMP = S_NUM + MUL_LAT + 1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    OC_SEP      = 3'd0,
    OC_COPLANAR = 3'd1,
    OC_OVERLAP  = 3'd2,
    OC_DISJOINT = 3'd3,
    OC_NOREF    = 3'd4
  } oc_e;

  typedef logic signed [COORD_W-1:0] crd_t;
  typedef crd_t [8:0]                 tri_t;
  typedef logic signed [EDGE_W-1:0]  edg_t;
  typedef logic signed [NPRD_W-1:0]  nprd_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;
  typedef logic signed [DPRD_W-1:0]  dprd_t;
  typedef logic signed [DST_W-1:0]   dst_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic signed [DEN_W-1:0]   den_t;
  typedef logic signed [MUL_W-1:0]   mop_t;
  typedef logic signed [PRD_W-1:0]   prd_t;
  typedef logic [2*MUL_CH-1:0]       mpp_t;
  typedef logic [MUL_RW-1:0]         mrow_t;
  typedef logic [MUL_TW-1:0]         mtot_t;

  // Early decision that bypasses the interval test.
  typedef struct packed {
    logic done;
    oc_e  oc;
  } fl_t;

  // Data carried through the plane stages.
  typedef struct packed {
    logic        noref;
    tri_t [1:0]  tr;
  } cr_t;

  // Data waiting for the line direction.
  typedef struct packed {
    fl_t              fl;
    tri_t [1:0]       tr;
    logic [1:0][1:0]  li;
    logic [1:0][1:0]  xa;
    logic [1:0][1:0]  xb;
    dst_t [1:0]       dl;
    dst_t [1:0]       d0;
    dst_t [1:0]       d1;
  } sd_t;

  // Data waiting for the crossing-point products.
  typedef struct packed {
    fl_t         fl;
    dst_t [1:0]  dl;
    dst_t [1:0]  d0;
    dst_t [1:0]  d1;
  } sp_t;

endpackage

`default_nettype wire

### rtl/tti_mul.sv
// Pipelined signed multiplier built from narrow partial products.
`default_nettype none

module tti_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  tti_pkg::mop_t a_i,
  input  tti_pkg::mop_t b_i,
  output tti_pkg::prd_t p_o
);

  logic [tti_pkg::MUL_W-1:0]   ua, ub;
  logic [tti_pkg::MUL_XW-1:0]  ma_q, mb_q;
  logic [tti_pkg::MUL_LAT-2:0] neg_q;
  tti_pkg::mpp_t               pp_q [tti_pkg::MUL_NC][tti_pkg::MUL_NC];
  tti_pkg::mrow_t              row_d [tti_pkg::MUL_NC];
  tti_pkg::mrow_t              row_q [tti_pkg::MUL_NC];
  tti_pkg::mtot_t              tot_d, tot_q;
  tti_pkg::prd_t               p_q;

  assign ua = a_i[tti_pkg::MUL_W-1] ? -a_i : a_i;
  assign ub = b_i[tti_pkg::MUL_W-1] ? -b_i : b_i;

  always_comb begin
    for (int i = 0; i < tti_pkg::MUL_NC; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < tti_pkg::MUL_NC; j++) begin
        row_d[i] = row_d[i] + (tti_pkg::mrow_t'(pp_q[i][j]) << (tti_pkg::MUL_CH * j));
      end
    end
    tot_d = '0;
    for (int i = 0; i < tti_pkg::MUL_NC; i++) begin
      tot_d = tot_d + (tti_pkg::mtot_t'(row_q[i]) << (tti_pkg::MUL_CH * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Magnitudes, then partial products, row sums, total and sign.
      ma_q     <= tti_pkg::MUL_XW'(ua);
      mb_q     <= tti_pkg::MUL_XW'(ub);
      neg_q[0] <= a_i[tti_pkg::MUL_W-1] ^ b_i[tti_pkg::MUL_W-1];
      for (int k = 1; k < tti_pkg::MUL_LAT - 1; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      for (int i = 0; i < tti_pkg::MUL_NC; i++) begin
        for (int j = 0; j < tti_pkg::MUL_NC; j++) begin
          pp_q[i][j] <= ma_q[i*tti_pkg::MUL_CH +: tti_pkg::MUL_CH] *
                        mb_q[j*tti_pkg::MUL_CH +: tti_pkg::MUL_CH];
        end
        row_q[i] <= row_d[i];
      end
      tot_q <= tot_d;
      p_q   <= neg_q[tti_pkg::MUL_LAT-2] ? tti_pkg::prd_t'(-tot_q) : tti_pkg::prd_t'(tot_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/triangle_triangle_intersect.sv
// Top level: streaming triangle-triangle intersection test against a held reference.
//
//  Channel  Dir  Handshake                    Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: 9 vertex coordinates, tuser: req_type
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: hit, outcome
//
// One word is accepted per cycle while the pipeline is not held. The depth of a test
// word's path is set by three chained wide multiplier units of five
// stages each (line direction, crossing points, interval compare) plus the plane stages.
// A load word updates the reference at once and produces no result.
// When the output register is full and not taken, the whole pipeline holds.
// Reset clears the valid bits and the reference-loaded flag only.
`default_nettype none

module triangle_triangle_intersect (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z (16 bits each)
  input  logic [tti_pkg::IN_TD_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit, outcome (3 bits), zero fill
  output logic [tti_pkg::OUT_TD_W-1:0] m_axis_tdata
);

  logic en, acc;

  // Reference triangle; vertices are undefined until the first load.
  tti_pkg::tri_t ref_v_q;
  logic          ref_valid_q;

  logic [tti_pkg::S_CMP:0] vld_q;
  tti_pkg::cr_t            cr_q [6];

  tti_pkg::edg_t   p1_e_q  [2][2][3];
  tti_pkg::edg_t   p1_df_q [2][3][3];
  tti_pkg::nprd_t  p2_pr_q [2][3][2];
  tti_pkg::edg_t   p2_df_q [2][3][3];
  tti_pkg::nrm_t   p3_n_q  [2][3];
  tti_pkg::edg_t   p3_df_q [2][3][3];
  tti_pkg::dprd_t  p4_dp_q [2][3][3];
  tti_pkg::dst_t   p5_d_q  [2][3];

  // Side data from the distance stage up to the axis stage.
  tti_pkg::sd_t    sd_d;
  tti_pkg::sd_t    sd_q [tti_pkg::MUL_LAT-2];

  // Axis stage.
  tti_pkg::crd_t   p9_pl_q [2];
  tti_pkg::crd_t   p9_p0_q [2];
  tti_pkg::crd_t   p9_p1_q [2];
  tti_pkg::sp_t    p9_sp_q;
  tti_pkg::sp_t    sp_q [tti_pkg::MUL_LAT];

  // Interval end points as fractions with positive denominators.
  tti_pkg::num_t   num_q [2][2];
  tti_pkg::den_t   den_q [2][2];
  tti_pkg::fl_t    pn_fl_q;
  tti_pkg::fl_t    fl_q [tti_pkg::MUL_LAT];

  logic [3:0]      le_q, ge_q;
  tti_pkg::fl_t    pc_fl_q;

  logic            m_valid_q, m_hit_q;
  tti_pkg::oc_e    m_oc_q;

  // Multiplier connections.
  tti_pkg::mop_t   dm_a [6], dm_b [6];
  tti_pkg::prd_t   dm_p [6];
  tti_pkg::mop_t   sm_a [8], sm_b [8];
  tti_pkg::prd_t   sm_p [8];
  tti_pkg::mop_t   cm_a [8], cm_b [8];
  tti_pkg::prd_t   cm_p [8];

  logic [2:0]      nz [2], ng [2];
  logic [1:0]      lone_c [2];
  logic [2:0]      dnz;
  logic [1:0]      ax;
  logic [3:0]      ixl [2], ix0 [2], ix1 [2];
  tti_pkg::den_t   draw [2][2];

  // The output register parts the two sides; everything moves when it can be refilled.
  assign en            = !m_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && en;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= 1'b0;
    end else if (acc && s_axis_tuser == tti_pkg::REQ_LOAD) begin
      ref_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser == tti_pkg::REQ_LOAD) begin
      ref_v_q <= tti_pkg::tri_t'(s_axis_tdata[tti_pkg::TRI_W-1:0]);
    end
  end

  // Valid bits; only test words travel down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[tti_pkg::S_CMP-1:0], acc && s_axis_tuser == tti_pkg::REQ_TEST};
      m_valid_q <= vld_q[tti_pkg::S_CMP];
    end
  end

  // Plane stages: edges, normal products, normals, distance products, distances.
  // The distance of a vertex to the other plane is the other normal dotted with
  // the vertex minus the other triangle's first vertex.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q[0].noref <= !ref_valid_q;
      cr_q[0].tr[0] <= ref_v_q;
      cr_q[0].tr[1] <= tti_pkg::tri_t'(s_axis_tdata[tti_pkg::TRI_W-1:0]);
      for (int k = 1; k < 6; k++) begin
        cr_q[k] <= cr_q[k-1];
      end
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          p1_e_q[t][0][c] <= tti_pkg::edg_t'(cr_q[0].tr[t][3+c]) -
                             tti_pkg::edg_t'(cr_q[0].tr[t][c]);
          p1_e_q[t][1][c] <= tti_pkg::edg_t'(cr_q[0].tr[t][6+c]) -
                             tti_pkg::edg_t'(cr_q[0].tr[t][c]);
          for (int i = 0; i < 3; i++) begin
            p1_df_q[t][i][c] <= tti_pkg::edg_t'(cr_q[0].tr[t][3*i+c]) -
                                tti_pkg::edg_t'(cr_q[0].tr[1-t][c]);
          end
          p2_pr_q[t][c][0] <= p1_e_q[t][0][(c+1)%3] * p1_e_q[t][1][(c+2)%3];
          p2_pr_q[t][c][1] <= p1_e_q[t][0][(c+2)%3] * p1_e_q[t][1][(c+1)%3];
          p3_n_q[t][c]     <= tti_pkg::nrm_t'(p2_pr_q[t][c][0]) -
                              tti_pkg::nrm_t'(p2_pr_q[t][c][1]);
          for (int i = 0; i < 3; i++) begin
            p4_dp_q[t][i][c] <= p3_n_q[1-t][c] * p3_df_q[t][i][c];
          end
        end
        for (int i = 0; i < 3; i++) begin
          p5_d_q[t][i] <= tti_pkg::dst_t'(p4_dp_q[t][i][0]) +
                          tti_pkg::dst_t'(p4_dp_q[t][i][1]) +
                          tti_pkg::dst_t'(p4_dp_q[t][i][2]);
        end
      end
      p2_df_q <= p1_df_q;
      p3_df_q <= p2_df_q;
    end
  end

  // The line direction is the cross product of the two normals; only which
  // components are nonzero matters, so each component is a pair of products.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dm_a[2*c]   = tti_pkg::mop_t'(p3_n_q[0][(c+1)%3]);
      dm_b[2*c]   = tti_pkg::mop_t'(p3_n_q[1][(c+2)%3]);
      dm_a[2*c+1] = tti_pkg::mop_t'(p3_n_q[0][(c+2)%3]);
      dm_b[2*c+1] = tti_pkg::mop_t'(p3_n_q[1][(c+1)%3]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_dir
    tti_mul u_mul (.clk_i(clk_i), .en_i(en), .a_i(dm_a[g]), .b_i(dm_b[g]), .p_o(dm_p[g]));
  end

  // Distance signs: plane tests and choice of the lone vertex.
  always_comb begin
    logic p01, p02, p12, cop, sep;
    cop = 1'b0;
    sep = 1'b0;
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 3; i++) begin
        nz[t][i] = |p5_d_q[t][i];
        ng[t][i] = p5_d_q[t][i][tti_pkg::DST_W-1];
      end
      p01 = nz[t][0] && nz[t][1] && (ng[t][0] == ng[t][1]);
      p02 = nz[t][0] && nz[t][2] && (ng[t][0] == ng[t][2]);
      p12 = nz[t][1] && nz[t][2] && (ng[t][1] == ng[t][2]);
      if (p01) begin
        lone_c[t] = 2'd2;
      end else if (p02) begin
        lone_c[t] = 2'd1;
      end else if (p12 || nz[t][0]) begin
        lone_c[t] = 2'd0;
      end else if (nz[t][1]) begin
        lone_c[t] = 2'd1;
      end else begin
        lone_c[t] = 2'd2;
      end
      cop = cop || (nz[t] == 3'b000);
      sep = sep || ((nz[t] == 3'b111) && (ng[t] == 3'b000 || ng[t] == 3'b111));
      sd_d.li[t] = lone_c[t];
      sd_d.xa[t] = (lone_c[t] == 2'd0) ? 2'd1 : 2'd0;
      sd_d.xb[t] = (lone_c[t] == 2'd2) ? 2'd1 : 2'd2;
      sd_d.dl[t] = p5_d_q[t][lone_c[t]];
      sd_d.d0[t] = p5_d_q[t][sd_d.xa[t]];
      sd_d.d1[t] = p5_d_q[t][sd_d.xb[t]];
      sd_d.tr[t] = cr_q[5].tr[t];
    end
    // Priority: no reference, then coplanar, then separated by a plane.
    if (cr_q[5].noref) begin
      sd_d.fl = '{done: 1'b1, oc: tti_pkg::OC_NOREF};
    end else if (cop) begin
      sd_d.fl = '{done: 1'b1, oc: tti_pkg::OC_COPLANAR};
    end else if (sep) begin
      sd_d.fl = '{done: 1'b1, oc: tti_pkg::OC_SEP};
    end else begin
      sd_d.fl = '{done: 1'b0, oc: tti_pkg::OC_DISJOINT};
    end
  end

  // Projection axis: first coordinate on which the line direction is nonzero.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dnz[c] = dm_p[2*c] != dm_p[2*c+1];
    end
    ax = dnz[0] ? 2'd0 : (dnz[1] ? 2'd1 : 2'd2);
    for (int t = 0; t < 2; t++) begin
      ixl[t] = 4'({sd_q[tti_pkg::MUL_LAT-3].li[t], 1'b0}) +
               4'(sd_q[tti_pkg::MUL_LAT-3].li[t]) + 4'(ax);
      ix0[t] = 4'({sd_q[tti_pkg::MUL_LAT-3].xa[t], 1'b0}) +
               4'(sd_q[tti_pkg::MUL_LAT-3].xa[t]) + 4'(ax);
      ix1[t] = 4'({sd_q[tti_pkg::MUL_LAT-3].xb[t], 1'b0}) +
               4'(sd_q[tti_pkg::MUL_LAT-3].xb[t]) + 4'(ax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_d;
      for (int k = 1; k < tti_pkg::MUL_LAT - 2; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      for (int t = 0; t < 2; t++) begin
        p9_pl_q[t] <= sd_q[tti_pkg::MUL_LAT-3].tr[t][ixl[t]];
        p9_p0_q[t] <= sd_q[tti_pkg::MUL_LAT-3].tr[t][ix0[t]];
        p9_p1_q[t] <= sd_q[tti_pkg::MUL_LAT-3].tr[t][ix1[t]];
      end
      p9_sp_q.fl <= sd_q[tti_pkg::MUL_LAT-3].fl;
      p9_sp_q.dl <= sd_q[tti_pkg::MUL_LAT-3].dl;
      p9_sp_q.d0 <= sd_q[tti_pkg::MUL_LAT-3].d0;
      p9_sp_q.d1 <= sd_q[tti_pkg::MUL_LAT-3].d1;
      sp_q[0]    <= p9_sp_q;
      for (int k = 1; k < tti_pkg::MUL_LAT; k++) begin
        sp_q[k] <= sp_q[k-1];
      end
    end
  end

  // Crossing point k of a triangle: (p_lone * d_k - p_k * d_lone) / (d_k - d_lone).
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      sm_a[4*t]   = tti_pkg::mop_t'(p9_pl_q[t]);
      sm_b[4*t]   = tti_pkg::mop_t'(p9_sp_q.d0[t]);
      sm_a[4*t+1] = tti_pkg::mop_t'(p9_p0_q[t]);
      sm_b[4*t+1] = tti_pkg::mop_t'(p9_sp_q.dl[t]);
      sm_a[4*t+2] = tti_pkg::mop_t'(p9_pl_q[t]);
      sm_b[4*t+2] = tti_pkg::mop_t'(p9_sp_q.d1[t]);
      sm_a[4*t+3] = tti_pkg::mop_t'(p9_p1_q[t]);
      sm_b[4*t+3] = tti_pkg::mop_t'(p9_sp_q.dl[t]);
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_span
    tti_mul u_mul (.clk_i(clk_i), .en_i(en), .a_i(sm_a[g]), .b_i(sm_b[g]), .p_o(sm_p[g]));
  end

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      draw[t][0] = tti_pkg::den_t'(sp_q[tti_pkg::MUL_LAT-1].d0[t]) -
                   tti_pkg::den_t'(sp_q[tti_pkg::MUL_LAT-1].dl[t]);
      draw[t][1] = tti_pkg::den_t'(sp_q[tti_pkg::MUL_LAT-1].d1[t]) -
                   tti_pkg::den_t'(sp_q[tti_pkg::MUL_LAT-1].dl[t]);
    end
  end

  // Fractions are normalized so that every denominator is positive.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 2; t++) begin
        for (int k = 0; k < 2; k++) begin
          if (draw[t][k][tti_pkg::DEN_W-1]) begin
            num_q[t][k] <= tti_pkg::num_t'(sm_p[4*t+2*k+1] - sm_p[4*t+2*k]);
            den_q[t][k] <= -draw[t][k];
          end else begin
            num_q[t][k] <= tti_pkg::num_t'(sm_p[4*t+2*k] - sm_p[4*t+2*k+1]);
            den_q[t][k] <= draw[t][k];
          end
        end
      end
      pn_fl_q <= sp_q[tti_pkg::MUL_LAT-1].fl;
      fl_q[0] <= pn_fl_q;
      for (int k = 1; k < tti_pkg::MUL_LAT; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // Cross-multiplied compares of every reference end point with every test end point.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        cm_a[2*i+j]   = tti_pkg::mop_t'(num_q[0][i]);
        cm_b[2*i+j]   = tti_pkg::mop_t'(den_q[1][j]);
        cm_a[4+2*i+j] = tti_pkg::mop_t'(num_q[1][j]);
        cm_b[4+2*i+j] = tti_pkg::mop_t'(den_q[0][i]);
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_cmp
    tti_mul u_mul (.clk_i(clk_i), .en_i(en), .a_i(cm_a[g]), .b_i(cm_b[g]), .p_o(cm_p[g]));
  end

  // The intervals overlap when some reference point lies at or below some test
  // point and some test point lies at or below some reference point.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        le_q[g] <= cm_p[g] <= cm_p[4+g];
        ge_q[g] <= cm_p[g] >= cm_p[4+g];
      end
      pc_fl_q <= fl_q[tti_pkg::MUL_LAT-1];
      if (pc_fl_q.done) begin
        m_hit_q <= 1'b0;
        m_oc_q  <= pc_fl_q.oc;
      end else if (|le_q && |ge_q) begin
        m_hit_q <= 1'b1;
        m_oc_q  <= tti_pkg::OC_OVERLAP;
      end else begin
        m_hit_q <= 1'b0;
        m_oc_q  <= tti_pkg::OC_DISJOINT;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_oc_q, m_hit_q};

endmodule

`default_nettype wire

### rtl/tti_chk.sv
// Port-level checker for the triangle-triangle intersection block, with its bind.
`default_nettype none

module tti_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [tti_pkg::IN_TD_W-1:0]  s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tti_pkg::OUT_TD_W-1:0] m_axis_tdata
);

  // A word that waits on the output holds its valid.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Hit is set exactly for the overlap outcome.
  a_hit_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == tti_pkg::OC_OVERLAP)))
    else $error("hit does not match outcome");

  // Outcome codes stay within the defined set and the fill bits stay zero.
  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:1] <= tti_pkg::OC_NOREF) &&
                      (m_axis_tdata[7:4] == 4'b0000))
    else $error("outcome out of range");

  // The input side only stalls behind a result that is not being taken.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind triangle_triangle_intersect tti_chk u_tti_chk (.*);

`default_nettype wire
